// File: rtl/core/wgsc_pkg.sv
// Shared types and constants for the waypoint steering controller.
`timescale 1ns / 1ps
`default_nettype none
package wgsc_pkg;
  localparam int CoordWidth = 16;
  localparam int AngWidth   = 16;
  localparam int CordWidth  = 28;
  localparam int ZWidth     = 18;
  localparam int DistWidth  = 20;
  localparam int LinWidth   = 20;
  localparam int RateWidth  = 19;

  localparam logic [1:0] CfgArrive    = 2'd0;
  localparam logic [1:0] CfgTolerance = 2'd1;
  localparam logic [1:0] CfgGain      = 2'd2;

  localparam logic signed [ZWidth-1:0] PiQ12     = 18'sd12868;
  localparam logic signed [ZWidth-1:0] TwoPiQ12  = 18'sd25736;
  localparam logic signed [ZWidth-1:0] HalfPiQ12 = 18'sd6434;
  localparam logic [15:0] InvGainQ16 = 16'd39797;

  typedef enum logic [2:0] {
    ST_IDLE, ST_LOAD, ST_CORDIC, ST_SCALE, ST_DECIDE, ST_MUL, ST_OUT
  } state_t;

  function automatic logic [12:0] atan_q12(input logic [4:0] i);
    logic [12:0] r;
    begin
      case (i)
        5'd0: r = 13'd3217;
        5'd1: r = 13'd1899;
        5'd2: r = 13'd1003;
        5'd3: r = 13'd509;
        5'd4: r = 13'd256;
        5'd5: r = 13'd128;
        5'd6: r = 13'd64;
        5'd7: r = 13'd32;
        5'd8: r = 13'd16;
        5'd9: r = 13'd8;
        5'd10: r = 13'd4;
        5'd11: r = 13'd2;
        5'd12: r = 13'd1;
        default: r = 13'd0;
      endcase
      return r;
    end
  endfunction
endpackage
`default_nettype wire

// File: rtl/core/wgsc_ram.sv
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none
module wgsc_ram #(
  parameter int Width = 32,
  parameter int Depth = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] addr,
  input  wire logic [Width-1:0]         wdata,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

// File: rtl/core/wgsc_cordic.sv
// Iterative CORDIC vectoring unit: one micro-rotation per cycle.
`timescale 1ns / 1ps
`default_nettype none
module wgsc_cordic #(
  parameter int Steps = 16
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 start,
  input  wire logic signed [wgsc_pkg::CoordWidth:0] dx,
  input  wire logic signed [wgsc_pkg::CoordWidth:0] dy,
  output logic                                      done,
  output logic signed [wgsc_pkg::CordWidth-1:0]     x_out,
  output logic signed [wgsc_pkg::ZWidth-1:0]        z_out
);
  import wgsc_pkg::*;
  localparam int NSteps = (Steps < 24) ? Steps : 24;

  logic signed [CordWidth-1:0] x, y, xs, ys, x0, y0;
  logic signed [ZWidth-1:0] z, z0;
  logic [4:0] step;
  logic busy;
  logic zero_vec;

  assign xs = x >>> step;
  assign ys = y >>> step;

  always_comb begin
    x0 = CordWidth'(dx) <<< 8;
    y0 = CordWidth'(dy) <<< 8;
    z0 = '0;
    if (dx < 0) begin
      if (dy >= 0) begin
        x0 = CordWidth'(dy) <<< 8;
        y0 = -(CordWidth'(dx) <<< 8);
        z0 = HalfPiQ12;
      end else begin
        x0 = -(CordWidth'(dy) <<< 8);
        y0 = CordWidth'(dx) <<< 8;
        z0 = -HalfPiQ12;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
      zero_vec <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
        x <= x0;
        y <= y0;
        z <= z0;
        zero_vec <= (dx == '0) && (dy == '0);
      end else if (busy) begin
        if (y >= 0) begin
          x <= x + ys;
          y <= y - xs;
          z <= z + ZWidth'(atan_q12(step));
        end else begin
          x <= x - ys;
          y <= y + xs;
          z <= z - ZWidth'(atan_q12(step));
        end
        if (step == 5'(NSteps - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        step <= step + 5'd1;
      end
    end
  end

  assign x_out = x;
  // zero vector has no bearing; report 0
  assign z_out = zero_vec ? '0 : z;
endmodule
`default_nettype wire

// File: rtl/core/waypoint_goal_steering_controller.sv
// Top level of the waypoint steering controller.
// Usage:
//   Input channel (in_valid/in_ready) takes waypoint (cmd=1) or pose (cmd=0)
//   requests. Waypoints are written into the path store as they are accepted.
//   A pose while running reads the goal, runs the CORDIC for up to
//   CORDIC_STEPS micro-rotations, then scales the distance, compares, and
//   multiplies by the gain in the same shared multiplier; in_ready is low
//   meanwhile.
//   Arrival or idle poses produce no result.
//   Results leave on out_valid/out_ready from an output register; while the
//   receiver stalls the block holds the result and accepts nothing more.
//   Reset (rst, synchronous) clears the path, goal and running flag and loads
//   default registers; the path store contents are not cleared.
//   Configuration writes (cfg_we/cfg_index/cfg_data) take effect at once.
`timescale 1ns / 1ps
`default_nettype none
module waypoint_goal_steering_controller #(
  parameter int PATH_DEPTH   = 256,
  parameter int CORDIC_STEPS = 16
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_we,
  input  wire logic [1:0]          cfg_index,
  input  wire logic [15:0]         cfg_data,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic                cmd,
  input  wire logic signed [15:0]  pos_x,
  input  wire logic signed [15:0]  pos_y,
  input  wire logic signed [15:0]  heading,
  input  wire logic                path_start,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [19:0]              linear_speed,
  output logic signed [18:0]       angular_rate
);
  import wgsc_pkg::*;
  localparam int AW = $clog2(PATH_DEPTH);
  localparam int LW = AW + 1;

  logic [15:0] arrive_distance;
  logic [14:0] heading_tolerance;
  logic [11:0] speed_gain;
  logic [LW-1:0] path_length, next_index;
  logic signed [15:0] goal_x, goal_y, hd, px, py;
  logic running;
  state_t state, state_next;

  logic ram_we;
  logic [AW-1:0] ram_addr;
  logic [31:0] ram_rdata;
  logic load_pending;

  logic cordic_start, cordic_done;
  logic signed [CordWidth-1:0] cx;
  logic signed [ZWidth-1:0] cz;
  logic signed [ZWidth-1:0] err;
  logic [DistWidth-1:0] goal_range;
  logic signed [28:0] mul_a;
  logic signed [17:0] mul_b;
  logic signed [44:0] prod;
  logic signed [44:0] prod_q;
  logic lin_zero;
  logic accept;

  assign accept = in_valid && in_ready;
  assign in_ready = (state == ST_IDLE) && !load_pending;

  wgsc_ram #(.Width(32), .Depth(PATH_DEPTH)) u_ram (
    .clk(clk), .we(ram_we), .addr(ram_addr),
    .wdata({pos_y, pos_x}), .rdata(ram_rdata)
  );

  always_comb begin
    ram_we = 1'b0;
    ram_addr = next_index[AW-1:0];
    if (accept && cmd) begin
      if (path_start) begin
        ram_we = 1'b1;
        ram_addr = '0;
      end else if (path_length < LW'(PATH_DEPTH)) begin
        ram_we = 1'b1;
        ram_addr = path_length[AW-1:0];
      end
    end
  end

  wgsc_cordic #(.Steps(CORDIC_STEPS)) u_cordic (
    .clk(clk), .rst(rst), .start(cordic_start),
    .dx(17'(goal_x) - 17'(px)), .dy(17'(goal_y) - 17'(py)),
    .done(cordic_done), .x_out(cx), .z_out(cz)
  );

  assign cordic_start = (state == ST_LOAD);
  assign prod = mul_a * mul_b;

  always_comb begin
    state_next = state;
    mul_a = '0;
    mul_b = '0;
    case (state)
      ST_IDLE: if (accept && !cmd && running) state_next = ST_LOAD;
      ST_LOAD: state_next = ST_CORDIC;
      ST_CORDIC: if (cordic_done) state_next = ST_SCALE;
      ST_SCALE: begin
        mul_a = (cx < 0) ? '0 : 29'(cx);
        mul_b = 18'(InvGainQ16);
        state_next = ST_DECIDE;
      end
      ST_DECIDE: begin
        mul_a = 29'(err);
        mul_b = 18'(speed_gain);
        state_next = (goal_range < 20'(arrive_distance)) ? ST_IDLE : ST_MUL;
      end
      ST_MUL: begin
        mul_a = 29'(goal_range);
        mul_b = 18'(speed_gain);
        state_next = ST_OUT;
      end
      ST_OUT: if (out_ready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      arrive_distance <= 16'd10;
      heading_tolerance <= 15'd20;
      speed_gain <= 12'd768;
      path_length <= '0;
      next_index <= '0;
      goal_x <= '0;
      goal_y <= '0;
      running <= 1'b0;
      load_pending <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CfgArrive: arrive_distance <= cfg_data;
          CfgTolerance: heading_tolerance <= cfg_data[14:0];
          CfgGain: speed_gain <= cfg_data[11:0];
          default: ;
        endcase
      end
      load_pending <= 1'b0;
      if (load_pending) begin
        goal_x <= ram_rdata[15:0];
        goal_y <= ram_rdata[31:16];
      end
      if (accept) begin
        px <= pos_x;
        py <= pos_y;
        hd <= heading;
        if (cmd) begin
          if (path_start) begin
            path_length <= LW'(1);
            next_index <= LW'(1);
            running <= 1'b1;
            goal_x <= pos_x;
            goal_y <= pos_y;
          end else if (path_length < LW'(PATH_DEPTH)) begin
            path_length <= path_length + LW'(1);
          end
        end
      end
      if (state == ST_SCALE) begin
        goal_range <= DistWidth'((prod + 45'sd8388608) >>> 24);
        err <= (cz - ZWidth'(hd) > PiQ12) ? cz - ZWidth'(hd) - TwoPiQ12 :
               (cz - ZWidth'(hd) < -PiQ12) ? cz - ZWidth'(hd) + TwoPiQ12 :
               cz - ZWidth'(hd);
      end
      if (state == ST_DECIDE) begin
        prod_q <= prod;
        lin_zero <= ((err < 0) ? -err : err) > ZWidth'(heading_tolerance);
        if (goal_range < 20'(arrive_distance)) begin
          if (next_index >= path_length) begin
            running <= 1'b0;
          end else begin
            load_pending <= 1'b1;
            next_index <= next_index + LW'(1);
          end
        end
      end
      if (state == ST_MUL) begin
        if ((prod_q >>> 8) > 45'sd262143) angular_rate <= 19'sd262143;
        else if ((prod_q >>> 8) < -45'sd262144) angular_rate <= -19'sd262144;
        else angular_rate <= 19'(prod_q >>> 8);
        if (lin_zero) linear_speed <= '0;
        else if ((prod >>> 8) > 45'sd1048575) linear_speed <= 20'hFFFFF;
        else linear_speed <= 20'(prod >>> 8);
        out_valid <= 1'b1;
      end
      if (out_valid && out_ready) out_valid <= 1'b0;
    end
  end
endmodule
`default_nettype wire

// File: rtl/core/wgsc_checker.sv
// Port-level checker for the waypoint steering controller, bound to the top.
`timescale 1ns / 1ps
`default_nettype none
module wgsc_port_checks (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic cmd,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic [19:0] linear_speed
);
  a_no_accept_with_result: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("input taken while result pending");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(linear_speed))
    else $error("result changed under stall");
  // waypoint requests never stall the input channel
  a_waypoint_fast: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && cmd |=> in_ready) else $error("busy after waypoint");
  a_reset_idle: assert property (@(posedge clk)
    $past(rst) |-> !out_valid) else $error("result after reset");
endmodule
bind waypoint_goal_steering_controller wgsc_port_checks u_chk (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready), .cmd(cmd),
  .out_valid(out_valid), .out_ready(out_ready), .linear_speed(linear_speed)
);
`default_nettype wire

// File: tb/wgsc_checker.sv
// Checker for the waypoint steering controller: steering predictor and result compare.
`timescale 1ns / 1ps
module wgsc_checker
  import wgsc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic               cmd,
  input  logic signed [15:0] pos_x,
  input  logic signed [15:0] pos_y,
  input  logic signed [15:0] heading,
  input  logic               path_start,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [19:0]        linear_speed,
  input  logic signed [18:0] angular_rate,
  output int                 fail_count,
  output int                 pending,
  output int                 results_seen
);
  localparam int Depth = 256;
  localparam int Steps = 16;

  typedef struct packed {
    logic [19:0]        lin;
    logic signed [18:0] ang;
  } steer_t;

  logic [31:0] waypoints [Depth];
  int unsigned wp_count, wp_next;
  logic signed [15:0] tgt_x, tgt_y;
  bit tracking;
  logic [15:0] arrive_q;
  logic [14:0] tol_q;
  logic [11:0] gain_q;
  steer_t steer_q[$];

  assign pending = steer_q.size();

  function automatic longint fdiv(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint atan_tab(int i);
    longint t [13] = '{3217, 1899, 1003, 509, 256, 128, 64, 32, 16, 8, 4, 2, 1};
    return (i < 13) ? t[i] : 0;
  endfunction

  // bearing and range of (dx,dy) by vectoring micro-rotations
  task automatic aim(input longint dx, input longint dy, output longint brg,
                     output longint rng);
    longint x, y, z, t, xs, ys;
    x = dx * 256; y = dy * 256; z = 0;
    if (dx == 0 && dy == 0) begin
      brg = 0; rng = 0; return;
    end
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y; y = -t; z = 6434;
      end else begin
        x = -y; y = t; z = -6434;
      end
    end
    for (int i = 0; i < Steps; i++) begin
      xs = fdiv(x, i); ys = fdiv(y, i);
      if (y >= 0) begin
        x = x + ys; y = y - xs; z += atan_tab(i);
      end else begin
        x = x - ys; y = y + xs; z -= atan_tab(i);
      end
    end
    if (x < 0) x = 0;
    brg = z;
    rng = (x * 39797 + (64'sd1 <<< 23)) >>> 24;
  endtask

  task automatic take_request();
    longint brg, rng, err, ang, lin, aerr;
    steer_t s;
    if (cmd) begin
      if (path_start) begin
        waypoints[0] = {pos_y, pos_x};
        wp_count = 1; wp_next = 1;
        tgt_x = pos_x; tgt_y = pos_y; tracking = 1;
      end else if (wp_count < Depth) begin
        waypoints[wp_count] = {pos_y, pos_x};
        wp_count++;
      end
      return;
    end
    if (!tracking) return;
    aim(longint'(tgt_x) - pos_x, longint'(tgt_y) - pos_y, brg, rng);
    if (rng < longint'(arrive_q)) begin
      if (wp_next >= wp_count) tracking = 0;
      else begin
        tgt_x = waypoints[wp_next][15:0];
        tgt_y = waypoints[wp_next][31:16];
        wp_next++;
      end
      return;
    end
    err = brg - heading;
    if (err > 12868) err -= 25736;
    else if (err < -12868) err += 25736;
    ang = fdiv(err * gain_q, 8);
    if (ang > 262143) ang = 262143;
    if (ang < -262144) ang = -262144;
    aerr = err < 0 ? -err : err;
    if (aerr > longint'(tol_q)) lin = 0;
    else begin
      lin = (rng * gain_q) >>> 8;
      if (lin > 1048575) lin = 1048575;
    end
    s.lin = lin[19:0]; s.ang = ang[18:0];
    steer_q.push_back(s);
  endtask

  always @(posedge clk) begin
    steer_t e;
    if (rst) begin
      wp_count <= 0; wp_next <= 0; tgt_x <= 0; tgt_y <= 0; tracking <= 0;
      arrive_q <= 16'd10; tol_q <= 15'd20; gain_q <= 12'd768;
      fail_count <= 0; results_seen <= 0;
      steer_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        results_seen <= results_seen + 1;
        if (steer_q.size() == 0) begin
          $error("unexpected result lin=%0d ang=%0d", linear_speed, angular_rate);
          fail_count <= fail_count + 1;
        end else begin
          e = steer_q.pop_front();
          if (e.lin !== linear_speed) begin
            $error("linear_speed exp %0d got %0d", e.lin, linear_speed);
            fail_count <= fail_count + 1;
          end
          if (e.ang !== angular_rate) begin
            $error("angular_rate exp %0d got %0d", e.ang, angular_rate);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_valid && in_ready) take_request();
      if (cfg_we) begin
        case (cfg_index)
          CfgArrive:    arrive_q <= cfg_data;
          CfgTolerance: tol_q <= cfg_data[14:0];
          CfgGain:      gain_q <= cfg_data[11:0];
          default: ;
        endcase
      end
    end
  end
endmodule

// File: tb/waypoint_goal_steering_controller_tb.sv
// Testbench top: stimulus, configuration phases and verdict for the steering controller.
`timescale 1ns / 1ps
module waypoint_goal_steering_controller_tb;
  import wgsc_pkg::*;

  logic clk = 0, rst = 1;
  logic cfg_we = 0;
  logic [1:0] cfg_index = CfgArrive;
  logic [15:0] cfg_data = 0;
  logic in_valid = 0, cmd = 0, path_start = 0, out_ready = 0;
  logic signed [15:0] pos_x = 0, pos_y = 0, heading = 0;
  logic in_ready, out_valid;
  logic [19:0] linear_speed;
  logic signed [18:0] angular_rate;
  int fail_count, pending, results_seen;
  int idle_cycles = 0, sent = 0;
  bit stall_mode = 0;

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  waypoint_goal_steering_controller i_dut (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data, .in_valid, .in_ready, .cmd,
    .pos_x, .pos_y, .heading, .path_start, .out_valid, .out_ready,
    .linear_speed, .angular_rate
  );

  wgsc_checker i_chk (.*);

  // receiver stall pattern: phases of always ready and of random stalls
  always @(negedge clk) begin
    if ($urandom_range(0, 63) == 0) stall_mode <= ~stall_mode;
    out_ready <= stall_mode ? ($urandom_range(0, 3) != 0) : 1'b1;
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 5000) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // valid is set and cleared immediately so back-to-back calls leave it high
  task automatic send(input bit c, input logic [15:0] x, input logic [15:0] y,
                      input logic [15:0] h, input bit s);
    cmd <= c; pos_x <= x; pos_y <= y; heading <= h; path_start <= s;
    in_valid = 1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    in_valid = 0;
    sent++;
  endtask

  task automatic drain();
    while (pending != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    cfg_we = 1; cfg_index <= idx; cfg_data <= val;
    @(negedge clk);
    cfg_we = 0;
  endtask

  task automatic rand_gap();
    if ($urandom_range(0, 7) == 0) repeat ($urandom_range(1, 30)) @(negedge clk);
  endtask

  // path of n points within +-span of the origin, then poses at, near or away from the first point
  task automatic run_path(input int n, input int poses, input int span);
    int gx, gy;
    gx = $urandom_range(0, 2 * span) - span;
    gy = $urandom_range(0, 2 * span) - span;
    send(1, gx, gy, $urandom, 1);
    for (int i = 1; i < n; i++)
      send(1, $urandom_range(0, 2 * span) - span, $urandom_range(0, 2 * span) - span,
           $urandom, $urandom_range(0, 9) == 0 && i > 2);
    for (int k = 0; k < poses; k++) begin
      rand_gap();
      case ($urandom_range(0, 5))
        0: send(0, gx, gy, $urandom, 0);
        1: send(0, gx + $urandom_range(0, 8) - 4, gy + $urandom_range(0, 8) - 4,
                $urandom, 0);
        2: send(0, $urandom, $urandom, $urandom, 0);
        default: send(0, $urandom_range(0, 2 * span) - span,
                      $urandom_range(0, 2 * span) - span,
                      $urandom_range(0, 60) - 30, 0);
      endcase
    end
  endtask

  initial begin
    repeat (10) @(negedge clk);
    rst <= 0;
    @(negedge clk);
    // directed: idle pose, appends while idle, extremes, arrival and wrap
    send(0, 0, 0, 0, 0);
    send(1, 100, 100, 0, 0);
    send(1, 16'h7fff, 16'h7fff, 0, 1);
    send(0, 16'h8000, 16'h8000, 16'h8000, 0);
    send(0, 16'h8000, 16'h7fff, 16'h7fff, 0);
    send(0, 16'h7fff, 16'h8000, 0, 0);
    send(1, 16'h8000, 16'h8000, 16'hffff, 0);
    send(1, 0, 0, 0, 0);
    send(0, 16'h7fff, 16'h7fff, 0, 0);
    send(0, 0, 0, 16'h7fff, 0);
    send(0, 16'h7fff, 0, 16'h8000, 0);
    send(0, 0, 0, 0, 0);
    send(0, 5, 5, 0, 0);
    send(1, 0, 0, 0, 1);
    send(0, 0, 0, 0, 0);
    send(0, 1, 2, 0, 0);
    drain();
    write_reg(CfgArrive, 16'hffff);
    write_reg(CfgTolerance, 16'h7fff);
    write_reg(CfgGain, 16'h0fff);
    send(1, 16'h4000, 16'hc000, 0, 1);
    send(0, 16'hc000, 16'h4000, 0, 0);
    send(0, 16'hc000, 16'h4000, 16'h7fff, 0);
    drain();
    // fill the path store past capacity
    write_reg(CfgArrive, 0);
    send(1, 1, 1, 0, 1);
    for (int i = 0; i < 260; i++) send(1, $urandom, $urandom, $urandom, 0);
    send(0, 0, 0, 0, 0);
    drain();
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin write_reg(CfgArrive, 10); write_reg(CfgTolerance, 20);
                 write_reg(CfgGain, 768); end
        1: begin write_reg(CfgArrive, 0); write_reg(CfgTolerance, 0);
                 write_reg(CfgGain, 0); end
        2: begin write_reg(CfgArrive, 16'hffff); write_reg(CfgTolerance, 16'h7fff);
                 write_reg(CfgGain, 16'hffff); end
        default: begin write_reg(CfgArrive, $urandom_range(0, 300));
                       write_reg(CfgTolerance, $urandom);
                       write_reg(CfgGain, $urandom); end
      endcase
      repeat (4) begin
        run_path($urandom_range(1, 6), $urandom_range(10, 20),
                 $urandom_range(0, 1) ? 200 : 30000);
        if ($urandom_range(0, 3) == 0) send(1, $urandom, $urandom, $urandom, 0);
      end
      drain();
    end
    $display("Sent %0d requests over reset, extreme and random register settings;",
             sent);
    $display("checked %0d steering results including a full path store.", results_seen);
    if (fail_count == 0 && pending == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end
endmodule

// File: waypoint_goal_steering_controller.f
rtl/core/wgsc_pkg.sv
rtl/core/wgsc_ram.sv
rtl/core/wgsc_cordic.sv
rtl/core/waypoint_goal_steering_controller.sv
rtl/core/wgsc_checker.sv
tb/wgsc_checker.sv
tb/waypoint_goal_steering_controller_tb.sv
